// ----- rtl/brng_pkg.sv -----
// shared constants, commands and types for the random number generator
`default_nettype none
package brng_pkg;
   localparam int unsigned WordWidth = 64;
   typedef logic [WordWidth-1:0] word_type;
   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_RESEED = 2'd0;
   localparam cmd_type CMD_RAW    = 2'd1;
   localparam cmd_type CMD_URANGE = 2'd2;
   localparam cmd_type CMD_SRANGE = 2'd3;

   localparam word_type SM_GAMMA = 64'h9E3779B97F4A7C15;
   localparam word_type SM_MUL1  = 64'hBF58476D1CE4E5B9;
   localparam word_type SM_MUL2  = 64'h94D049BB133111EB;
   localparam word_type SIGN_BIT = 64'h8000000000000000;
   localparam word_type ALL_ONES = 64'hFFFFFFFFFFFFFFFF;

   typedef struct packed {
      cmd_type  cmd;
      word_type low_bound;
      word_type high_bound;
      word_type entropy;
   } req_type;

   typedef struct packed {
      word_type value;
   } rsp_type;

   // unit request between the sequencer and the serial arithmetic unit
   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_DIV = 2'd1;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
      word_type   a;
      word_type   b;
   } unit_req_type;

   typedef struct packed {
      logic     done;
      word_type result;
   } unit_rsp_type;
endpackage
`default_nettype wire

// ----- rtl/brng_if.sv -----
// valid/ready channel interface
`default_nettype none
interface brng_if #(type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/brng_serial_unit.sv -----
// bit-serial 64-bit multiplier (low half) and restoring divider
`default_nettype none
module brng_serial_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire brng_pkg::unit_req_type unit_req,
   output brng_pkg::unit_rsp_type     unit_rsp
);
   import brng_pkg::*;

   logic       busy_ff, busy_in;
   logic [1:0] op_ff, op_in;
   logic [6:0] count_ff, count_in;
   word_type   acc_ff, acc_in;
   word_type   sh_ff, sh_in;
   word_type   opb_ff, opb_in;
   logic       done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      busy_in  = busy_ff;
      op_in    = op_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      sh_in    = sh_ff;
      opb_in   = opb_ff;
      done_in  = 1'b0;
      trial    = '0;
      if (!busy_ff) begin
         if (unit_req.start) begin
            busy_in  = 1'b1;
            op_in    = unit_req.op;
            count_in = '0;
            acc_in   = '0;
            sh_in    = unit_req.a;
            opb_in   = unit_req.b;
         end
      end else if (op_ff == OP_MUL) begin
         // multiplicand shifts left, multiplier shifts right
         if (sh_ff[0]) acc_in = acc_ff + opb_ff;
         sh_in    = {1'b0, sh_ff[63:1]};
         opb_in   = {opb_ff[62:0], 1'b0};
         count_in = count_ff + 7'd1;
         if (count_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // restoring division, quotient bits enter sh from the right
         trial = {acc_ff, sh_ff[63]} - {1'b0, opb_ff};
         if (!trial[64]) begin
            acc_in = trial[63:0];
            sh_in  = {sh_ff[62:0], 1'b1};
         end else begin
            acc_in = {acc_ff[62:0], sh_ff[63]};
            sh_in  = {sh_ff[62:0], 1'b0};
         end
         count_in = count_ff + 7'd1;
         if (count_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      count_ff <= count_in;
      acc_ff   <= acc_in;
      sh_ff    <= sh_in;
      opb_ff   <= opb_in;
   end

   // acc holds the product for multiply; sh holds the quotient for divide
   assign unit_rsp.done   = done_ff;
   assign unit_rsp.result = (op_ff == OP_MUL) ? acc_ff : sh_ff;
endmodule
`default_nettype wire

// ----- rtl/brng_core.sv -----
// command sequencer: seeding, xorshift128+ state and range reduction
`default_nettype none
module brng_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   brng_if.sink                        req,
   brng_if.source                      rsp,
   output brng_pkg::unit_req_type      unit_req,
   input  wire brng_pkg::unit_rsp_type unit_rsp
);
   import brng_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_SM_ADD = 4'd2;
   localparam logic [3:0] ST_SM_M1  = 4'd3;
   localparam logic [3:0] ST_SM_M2  = 4'd4;
   localparam logic [3:0] ST_SM_END = 4'd5;
   localparam logic [3:0] ST_AFTSD  = 4'd6;
   localparam logic [3:0] ST_DIVD   = 4'd7;
   localparam logic [3:0] ST_DRAW   = 4'd8;
   localparam logic [3:0] ST_DIVR   = 4'd9;
   localparam logic [3:0] ST_CHECK  = 4'd10;
   localparam logic [3:0] ST_OUT    = 4'd11;

   logic [3:0] state_ff, state_in;
   word_type   a_ff, a_in, b_ff, b_in;
   cmd_type    cmd_ff, cmd_in;
   word_type   lo_ff, lo_in, hi_ff, hi_in, ctr_ff, ctr_in;
   word_type   span_ff, span_in, d_ff, d_in, z_ff, z_in;
   logic       second_ff, second_in;
   logic       wait_ff, wait_in;
   logic       out_valid_ff, out_valid_in;
   word_type   out_ff, out_in;
   unit_req_type ureq;
   word_type   xs, nb, raw;
   logic       ge;

   always_comb begin
      xs  = a_ff ^ (a_ff << 23);
      nb  = xs ^ b_ff ^ (xs >> 18) ^ (b_ff >> 5);
      raw = nb + b_ff;
      ge  = (cmd_ff == CMD_URANGE) ? (lo_ff >= hi_ff)
                                   : ((lo_ff ^ SIGN_BIT) >= (hi_ff ^ SIGN_BIT));
   end

   assign req.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload.value = out_ff;
   assign unit_req = ureq;

   always_comb begin
      state_in     = state_ff;
      a_in = a_ff; b_in = b_ff; cmd_in = cmd_ff; lo_in = lo_ff; hi_in = hi_ff;
      ctr_in = ctr_ff; span_in = span_ff; d_in = d_ff; z_in = z_ff;
      second_in    = second_ff;
      wait_in      = wait_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      ureq         = '0;
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.payload.cmd;
               lo_in  = req.payload.low_bound;
               hi_in  = req.payload.high_bound;
               ctr_in = req.payload.entropy;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            second_in = 1'b0;
            if (cmd_ff == CMD_RESEED || (a_ff == '0 && b_ff == '0)) state_in = ST_SM_ADD;
            else state_in = ST_AFTSD;
         end
         ST_SM_ADD: begin
            z_in   = ctr_ff + SM_GAMMA;
            ctr_in = ctr_ff + SM_GAMMA;
            wait_in = 1'b0;
            state_in = ST_SM_M1;
         end
         ST_SM_M1: begin
            if (!wait_ff) begin
               ureq.start = 1'b1; ureq.op = OP_MUL;
               ureq.a = z_ff ^ (z_ff >> 30); ureq.b = SM_MUL1;
               wait_in = 1'b1;
            end else if (unit_rsp.done) begin
               z_in = unit_rsp.result; wait_in = 1'b0; state_in = ST_SM_M2;
            end
         end
         ST_SM_M2: begin
            if (!wait_ff) begin
               ureq.start = 1'b1; ureq.op = OP_MUL;
               ureq.a = z_ff ^ (z_ff >> 27); ureq.b = SM_MUL2;
               wait_in = 1'b1;
            end else if (unit_rsp.done) begin
               z_in = unit_rsp.result; wait_in = 1'b0; state_in = ST_SM_END;
            end
         end
         ST_SM_END: begin
            if (!second_ff) begin
               a_in = z_ff ^ (z_ff >> 31);
               second_in = 1'b1;
               state_in = ST_SM_ADD;
            end else begin
               b_in = z_ff ^ (z_ff >> 31);
               if (cmd_ff == CMD_RESEED) begin
                  out_in = '0; out_valid_in = 1'b1; state_in = ST_IDLE;
               end else state_in = ST_AFTSD;
            end
         end
         ST_AFTSD: begin
            if (cmd_ff == CMD_RAW) begin
               a_in = b_ff; b_in = nb; out_in = raw; out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (ge && lo_ff == hi_ff) begin
               out_in = lo_ff; out_valid_in = 1'b1; state_in = ST_IDLE;
            end else begin
               if (ge) begin
                  lo_in = hi_ff; hi_in = lo_ff;
                  span_in = lo_ff - hi_ff + 64'd1;
               end else span_in = hi_ff - lo_ff + 64'd1;
               wait_in = 1'b0;
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (span_ff == '0) begin
               a_in = b_ff; b_in = nb; out_in = raw; out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (!wait_ff) begin
               ureq.start = 1'b1; ureq.op = OP_DIV; ureq.a = ALL_ONES; ureq.b = span_ff;
               wait_in = 1'b1;
            end else if (unit_rsp.done) begin
               d_in = unit_rsp.result; wait_in = 1'b0; state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            a_in = b_ff; b_in = nb; z_in = raw;
            state_in = ST_DIVR;
         end
         ST_DIVR: begin
            if (!wait_ff) begin
               ureq.start = 1'b1; ureq.op = OP_DIV; ureq.a = z_ff; ureq.b = d_ff;
               wait_in = 1'b1;
            end else if (unit_rsp.done) begin
               z_in = unit_rsp.result; wait_in = 1'b0; state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (z_ff >= span_ff) state_in = ST_DRAW;
            else state_in = ST_OUT;
         end
         ST_OUT: begin
            out_in = lo_ff + z_ff; out_valid_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_ff         <= '0;
         b_ff         <= '0;
         wait_ff      <= 1'b0;
         second_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         wait_ff      <= wait_in;
         second_ff    <= second_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff  <= cmd_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      ctr_ff  <= ctr_in;
      span_ff <= span_in;
      d_ff    <= d_in;
      z_ff    <= z_in;
      out_ff  <= out_in;
   end
endmodule
`default_nettype wire

// ----- rtl/bounded_random_number_generator.sv -----
// top level of the bounded random number generator
//  channel | dir | payload
//  req     | in  | cmd, low_bound, high_bound, entropy
//  rsp     | out | value
// raw draw or equal bounds: the request is decoded, then the result is registered for output
// seeding (reseed, or a draw from zero state) runs per state word a gamma add and two multiplies
// range draw adds a division for the limit, a draw and a division per attempt, and a step to add the low bound
// multiplies and divisions run on the bit-serial multiply/divide unit; one item at a time
// reset (synchronous) clears the generator state to zero
// a result waits in its output register until taken; no new transfer meanwhile
`default_nettype none
module bounded_random_number_generator (
   input  wire logic clock,
   input  wire logic reset,
   brng_if.sink      req,
   brng_if.source    rsp
);
   import brng_pkg::*;

   unit_req_type unit_req;
   unit_rsp_type unit_rsp;

   brng_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   brng_serial_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );
endmodule
`default_nettype wire
